// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// Break classes, pictograph spans and shared types of the cluster break block.
// ----------------------------------------------------------------------------
package gcb_pkg;

  localparam int CP_W  = 21;
  localparam int CLS_W = 5;

  localparam logic [CLS_W-1:0] CLS_OTHER = 5'd0;
  localparam logic [CLS_W-1:0] CLS_CR    = 5'd1;
  localparam logic [CLS_W-1:0] CLS_LF    = 5'd2;
  localparam logic [CLS_W-1:0] CLS_CTL   = 5'd3;
  localparam logic [CLS_W-1:0] CLS_EXT   = 5'd4;
  localparam logic [CLS_W-1:0] CLS_ZWJ   = 5'd5;
  localparam logic [CLS_W-1:0] CLS_RI    = 5'd6;
  localparam logic [CLS_W-1:0] CLS_PP    = 5'd7;
  localparam logic [CLS_W-1:0] CLS_SM    = 5'd8;
  localparam logic [CLS_W-1:0] CLS_L     = 5'd9;
  localparam logic [CLS_W-1:0] CLS_V     = 5'd10;
  localparam logic [CLS_W-1:0] CLS_T     = 5'd11;
  localparam logic [CLS_W-1:0] CLS_LV    = 5'd12;
  localparam logic [CLS_W-1:0] CLS_LVT   = 5'd13;
  localparam logic [CLS_W-1:0] CLS_EB    = 5'd14;
  localparam logic [CLS_W-1:0] CLS_EM    = 5'd15;
  localparam logic [CLS_W-1:0] CLS_GAZ   = 5'd16;
  localparam logic [CLS_W-1:0] CLS_EBG   = 5'd17;

  localparam logic [CP_W-1:0] CP_ASTERISK = 21'h0002A;
  localparam logic [CP_W-1:0] CP_HASH     = 21'h00023;
  localparam logic [CP_W-1:0] CP_DIGIT_0  = 21'h00030;
  localparam logic [CP_W-1:0] CP_DIGIT_9  = 21'h00039;
  localparam logic [CP_W-1:0] CP_COPYRIGHT = 21'h000A9;
  localparam logic [CP_W-1:0] CP_REGISTERED = 21'h000AE;
  localparam logic [CP_W-1:0] CP_TRADEMARK = 21'h02122;
  localparam logic [CP_W-1:0] CP_WAVY_DASH = 21'h03030;
  localparam logic [CP_W-1:0] CP_PART_ALT  = 21'h0303D;

  typedef struct packed {
    logic [CP_W-1:0] lo;
    logic [CP_W-1:0] hi;
  } pict_span_t;

  localparam int PICT_SPAN_COUNT = 106;

  localparam pict_span_t PICT_SPANS [PICT_SPAN_COUNT] = '{
    '{21'h1F774, 21'h1F77F}, '{21'h02700, 21'h02701}, '{21'h02703, 21'h02704},
    '{21'h0270E, 21'h0270E}, '{21'h02710, 21'h02711}, '{21'h02765, 21'h02767},
    '{21'h1F030, 21'h1F09F}, '{21'h1F10D, 21'h1F10F}, '{21'h1F12F, 21'h1F12F},
    '{21'h1F16C, 21'h1F16F}, '{21'h1F1AD, 21'h1F1E5}, '{21'h1F203, 21'h1F20F},
    '{21'h1F23C, 21'h1F23F}, '{21'h1F249, 21'h1F24F}, '{21'h1F252, 21'h1F2FF},
    '{21'h1F7D5, 21'h1F7FF}, '{21'h1F000, 21'h1F003}, '{21'h1F005, 21'h1F02F},
    '{21'h1F322, 21'h1F323}, '{21'h1F394, 21'h1F395}, '{21'h1F398, 21'h1F398},
    '{21'h1F39C, 21'h1F39D}, '{21'h1F3F1, 21'h1F3F2}, '{21'h1F3F6, 21'h1F3F6},
    '{21'h1F4FE, 21'h1F4FE}, '{21'h1F53E, 21'h1F548}, '{21'h1F54F, 21'h1F54F},
    '{21'h1F568, 21'h1F56E}, '{21'h1F571, 21'h1F572}, '{21'h1F57B, 21'h1F586},
    '{21'h1F588, 21'h1F589}, '{21'h1F58E, 21'h1F58F}, '{21'h1F591, 21'h1F594},
    '{21'h1F597, 21'h1F5A3}, '{21'h1F5A6, 21'h1F5A7}, '{21'h1F5A9, 21'h1F5B0},
    '{21'h1F5B3, 21'h1F5BB}, '{21'h1F5BD, 21'h1F5C1}, '{21'h1F5C5, 21'h1F5D0},
    '{21'h1F5D4, 21'h1F5DB}, '{21'h1F5DF, 21'h1F5E0}, '{21'h1F5E2, 21'h1F5E2},
    '{21'h1F5E4, 21'h1F5E7}, '{21'h1F5E9, 21'h1F5EE}, '{21'h1F5F0, 21'h1F5F2},
    '{21'h1F5F4, 21'h1F5F9}, '{21'h02605, 21'h02605}, '{21'h02607, 21'h0260D},
    '{21'h0260F, 21'h02610}, '{21'h02612, 21'h02612}, '{21'h02616, 21'h02617},
    '{21'h02619, 21'h0261C}, '{21'h0261E, 21'h0261F}, '{21'h02621, 21'h02621},
    '{21'h02624, 21'h02625}, '{21'h02627, 21'h02629}, '{21'h0262B, 21'h0262D},
    '{21'h02630, 21'h02637}, '{21'h0263B, 21'h02647}, '{21'h02654, 21'h0265F},
    '{21'h02661, 21'h02662}, '{21'h02664, 21'h02664}, '{21'h02667, 21'h02667},
    '{21'h02669, 21'h0267A}, '{21'h0267C, 21'h0267E}, '{21'h02680, 21'h02691},
    '{21'h02695, 21'h02695}, '{21'h02698, 21'h02698}, '{21'h0269A, 21'h0269A},
    '{21'h0269D, 21'h0269F}, '{21'h026A2, 21'h026A9}, '{21'h026AC, 21'h026AF},
    '{21'h026B2, 21'h026BC}, '{21'h026BF, 21'h026C3}, '{21'h026C6, 21'h026C7},
    '{21'h026C9, 21'h026CD}, '{21'h026D0, 21'h026D0}, '{21'h026D2, 21'h026D2},
    '{21'h026D5, 21'h026E8}, '{21'h026EB, 21'h026EF}, '{21'h026F6, 21'h026F6},
    '{21'h026FB, 21'h026FC}, '{21'h026FE, 21'h026FF}, '{21'h02388, 21'h02388},
    '{21'h1FA00, 21'h1FFFD}, '{21'h1F0A0, 21'h1F0FF}, '{21'h1F80C, 21'h1F80F},
    '{21'h1F848, 21'h1F84F}, '{21'h1F85A, 21'h1F85F}, '{21'h1F888, 21'h1F88F},
    '{21'h1F8AE, 21'h1F90F}, '{21'h1F91F, 21'h1F91F}, '{21'h1F928, 21'h1F92F},
    '{21'h1F931, 21'h1F932}, '{21'h1F93F, 21'h1F93F}, '{21'h1F94C, 21'h1F94F},
    '{21'h1F95F, 21'h1F97F}, '{21'h1F992, 21'h1F9BF}, '{21'h1F9C1, 21'h1F9FF},
    '{21'h1F6C6, 21'h1F6CA}, '{21'h1F6E6, 21'h1F6E8}, '{21'h1F6EA, 21'h1F6EA},
    '{21'h1F6F1, 21'h1F6F2}, '{21'h1F6D3, 21'h1F6DF}, '{21'h1F6ED, 21'h1F6EF},
    '{21'h1F6F7, 21'h1F6FF}
  };

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [CLS_W-1:0] break_class;
    logic             is_emoji;
    logic             last_in_text;
  } item_t;

  typedef struct packed {
    logic             step;
    logic [CLS_W-1:0] cls;
    logic             pict;
    logic             last;
  } rule_in_t;

endpackage

// ===== rtl/core/gcb_pict.sv =====
// ----------------------------------------------------------------------------
// gcb_pict
// Classifies a code point as an extended pictograph for emoji sequences.
// ----------------------------------------------------------------------------
module gcb_pict (
  input  logic [gcb_pkg::CP_W-1:0]  code_point,
  input  logic [gcb_pkg::CLS_W-1:0] break_class,
  input  logic                      is_emoji,
  output logic                      pict
);

  logic span_hit;
  logic keycap_like;
  logic emoji_pict;

  always_comb begin
    span_hit = 1'b0;
    for (int i = 0; i < gcb_pkg::PICT_SPAN_COUNT; i++) begin
      if (code_point >= gcb_pkg::PICT_SPANS[i].lo &&
          code_point <= gcb_pkg::PICT_SPANS[i].hi) begin
        span_hit = 1'b1;
      end
    end
  end

  assign keycap_like = (code_point == gcb_pkg::CP_ASTERISK) ||
                       (code_point == gcb_pkg::CP_HASH) ||
                       (code_point >= gcb_pkg::CP_DIGIT_0 &&
                        code_point <= gcb_pkg::CP_DIGIT_9) ||
                       (code_point == gcb_pkg::CP_COPYRIGHT) ||
                       (code_point == gcb_pkg::CP_REGISTERED) ||
                       (code_point == gcb_pkg::CP_TRADEMARK) ||
                       (code_point == gcb_pkg::CP_WAVY_DASH) ||
                       (code_point == gcb_pkg::CP_PART_ALT);

  assign emoji_pict = is_emoji && (break_class != gcb_pkg::CLS_RI) && !keycap_like;

  assign pict = span_hit || emoji_pict;

endmodule

// ===== rtl/core/gcb_rules.sv =====
// ----------------------------------------------------------------------------
// gcb_rules
// Boundary rules and the running flags that stand in for backward scans.
// ----------------------------------------------------------------------------
module gcb_rules (
  input  logic              clk,
  input  logic              rst_n,
  input  gcb_pkg::rule_in_t rin,
  output logic              brk
);

  logic                      have_prev_r, have_prev_nxt;
  logic [gcb_pkg::CLS_W-1:0] prev_cls_r, prev_cls_nxt;
  logic                      base_run_r, base_run_nxt;
  logic                      pict_run_r, pict_run_nxt;
  logic                      zwj_pict_r, zwj_pict_nxt;
  logic                      ri_odd_r, ri_odd_nxt;

  logic [gcb_pkg::CLS_W-1:0] c;
  logic                      c_ctl;
  logic                      p_ctl;

  assign c     = (rin.cls > gcb_pkg::CLS_EBG) ? gcb_pkg::CLS_OTHER : rin.cls;
  assign c_ctl = (c == gcb_pkg::CLS_CR) || (c == gcb_pkg::CLS_LF) || (c == gcb_pkg::CLS_CTL);
  assign p_ctl = (prev_cls_r == gcb_pkg::CLS_CR) || (prev_cls_r == gcb_pkg::CLS_LF) ||
                 (prev_cls_r == gcb_pkg::CLS_CTL);

  always_comb begin
    if (!have_prev_r) begin
      brk = 1'b1;
    end else if (prev_cls_r == gcb_pkg::CLS_CR && c == gcb_pkg::CLS_LF) begin
      brk = 1'b0;
    end else if (p_ctl || c_ctl) begin
      brk = 1'b1;
    end else if (prev_cls_r == gcb_pkg::CLS_L &&
                 (c == gcb_pkg::CLS_L || c == gcb_pkg::CLS_V ||
                  c == gcb_pkg::CLS_LV || c == gcb_pkg::CLS_LVT)) begin
      brk = 1'b0;
    end else if ((prev_cls_r == gcb_pkg::CLS_LV || prev_cls_r == gcb_pkg::CLS_V) &&
                 (c == gcb_pkg::CLS_V || c == gcb_pkg::CLS_T)) begin
      brk = 1'b0;
    end else if ((prev_cls_r == gcb_pkg::CLS_LVT || prev_cls_r == gcb_pkg::CLS_T) &&
                 c == gcb_pkg::CLS_T) begin
      brk = 1'b0;
    end else if (c == gcb_pkg::CLS_EXT || c == gcb_pkg::CLS_ZWJ || c == gcb_pkg::CLS_SM) begin
      brk = 1'b0;
    end else if (prev_cls_r == gcb_pkg::CLS_PP) begin
      brk = 1'b0;
    end else if (c == gcb_pkg::CLS_EM && base_run_r) begin
      brk = 1'b0;
    end else if (zwj_pict_r && rin.pict) begin
      brk = 1'b0;
    end else if (prev_cls_r == gcb_pkg::CLS_RI && c == gcb_pkg::CLS_RI && ri_odd_r) begin
      brk = 1'b0;
    end else begin
      brk = 1'b1;
    end
  end

  always_comb begin
    have_prev_nxt = have_prev_r;
    prev_cls_nxt  = prev_cls_r;
    base_run_nxt  = base_run_r;
    pict_run_nxt  = pict_run_r;
    zwj_pict_nxt  = zwj_pict_r;
    ri_odd_nxt    = ri_odd_r;
    if (rin.step) begin
      if (rin.last) begin
        have_prev_nxt = 1'b0;
        prev_cls_nxt  = gcb_pkg::CLS_OTHER;
        base_run_nxt  = 1'b0;
        pict_run_nxt  = 1'b0;
        zwj_pict_nxt  = 1'b0;
        ri_odd_nxt    = 1'b0;
      end else begin
        zwj_pict_nxt = (c == gcb_pkg::CLS_ZWJ) && pict_run_r;
        if (c != gcb_pkg::CLS_EXT) begin
          base_run_nxt = (c == gcb_pkg::CLS_EB) || (c == gcb_pkg::CLS_EBG);
          pict_run_nxt = rin.pict;
        end
        if (c == gcb_pkg::CLS_RI) begin
          ri_odd_nxt = (have_prev_r && prev_cls_r == gcb_pkg::CLS_RI) ? !ri_odd_r : 1'b1;
        end else begin
          ri_odd_nxt = 1'b0;
        end
        prev_cls_nxt  = c;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_cls_r  <= gcb_pkg::CLS_OTHER;
      base_run_r  <= 1'b0;
      pict_run_r  <= 1'b0;
      zwj_pict_r  <= 1'b0;
      ri_odd_r    <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
      prev_cls_r  <= prev_cls_nxt;
      base_run_r  <= base_run_nxt;
      pict_run_r  <= pict_run_nxt;
      zwj_pict_r  <= zwj_pict_nxt;
      ri_odd_r    <= ri_odd_nxt;
    end
  end

endmodule

// ===== rtl/core/grapheme_cluster_break_detector.sv =====
// ----------------------------------------------------------------------------
// grapheme_cluster_break_detector
// Grapheme cluster boundary marking for a code point stream.
// ----------------------------------------------------------------------------
// One code point is taken per cycle while the output is not stalled. Each
// accepted item passes through an input register and an output register; the
// rule decision and the running flags it depends on are settled between those
// registers. The output register parts the two sides, so one more item is
// taken while a result waits.
// break_before is always set on the first item after reset or after an item
// flagged last_in_text, and text_end echoes that flag.
module grapheme_cluster_break_detector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gcb_pkg::CP_W-1:0]  in_code_point,
  input  logic [gcb_pkg::CLS_W-1:0] in_break_class,
  input  logic                      in_is_emoji,
  input  logic                      in_last_in_text,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gcb_pkg::CP_W-1:0]  out_echo_point,
  output logic                      out_break_before,
  output logic                      out_text_end
);

  logic                     in_v_r, in_v_nxt;
  gcb_pkg::item_t           item_r;
  logic                     out_v_r, out_v_nxt;
  logic [gcb_pkg::CP_W-1:0] echo_r;
  logic                     brk_r;
  logic                     end_r;

  logic                     advance;
  logic                     pict;
  logic                     brk;
  gcb_pkg::rule_in_t        rin;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  gcb_pict u_pict (
    .code_point  (item_r.code_point),
    .break_class (item_r.break_class),
    .is_emoji    (item_r.is_emoji),
    .pict        (pict)
  );

  assign rin.step = advance;
  assign rin.cls  = item_r.break_class;
  assign rin.pict = pict;
  assign rin.last = item_r.last_in_text;

  gcb_rules u_rules (
    .clk   (clk),
    .rst_n (rst_n),
    .rin   (rin),
    .brk   (brk)
  );

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_ready) begin
      in_v_nxt = in_valid;
    end
    out_v_nxt = out_v_r;
    if (advance) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.code_point   <= in_code_point;
      item_r.break_class  <= in_break_class;
      item_r.is_emoji     <= in_is_emoji;
      item_r.last_in_text <= in_last_in_text;
    end
    if (advance) begin
      echo_r <= item_r.code_point;
      brk_r  <= brk;
      end_r  <= item_r.last_in_text;
    end
  end

  assign out_valid        = out_v_r;
  assign out_echo_point   = echo_r;
  assign out_break_before = brk_r;
  assign out_text_end     = end_r;

endmodule

// ===== rtl/core/gcb_checker.sv =====
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks of the cluster break block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gcb_pkg::CP_W-1:0]  out_echo_point,
  input logic                      out_break_before,
  input logic                      out_text_end
);

  logic       first_r, first_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    first_nxt = first_r;
    if (out_acc) begin
      first_nxt = out_text_end;
    end
    cnt_nxt = cnt_r + {2'b00, in_acc} - {2'b00, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      cnt_r   <= 3'd0;
    end else begin
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `CHK_IMPLIES(a_text_start_breaks, out_valid && first_r, out_break_before)
  `CHK_IMPLIES(a_in_flight_bound, 1'b1, cnt_r <= 3'd2)
  `CHK_IMPLIES(a_out_has_item, out_valid, cnt_r != 3'd0)
  `CHK_IMPLIES(a_ready_follows_sink, out_ready, in_ready)
  `CHK_NEXT(a_out_hold, out_valid && !out_ready,
            out_valid && $stable(out_echo_point) && $stable(out_break_before))

endmodule

bind grapheme_cluster_break_detector gcb_checker u_gcb_checker (.*);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Grapheme cluster break detector testbench
// Feeds code point streams through valid/ready handshakes with random idling
// on both sides. A scoreboard tracks the cluster rules on its own running
// flags and checks every result item against the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gcb_pkg::*;

  localparam int SPAN_COUNT  = 106;
  localparam int QUIET_LIMIT = 2000;

  localparam int unsigned PICT_SPAN [SPAN_COUNT][2] = '{
    '{'h1F774, 'h1F77F}, '{'h02700, 'h02701}, '{'h02703, 'h02704}, '{'h0270E, 'h0270E},
    '{'h02710, 'h02711}, '{'h02765, 'h02767}, '{'h1F030, 'h1F09F}, '{'h1F10D, 'h1F10F},
    '{'h1F12F, 'h1F12F}, '{'h1F16C, 'h1F16F}, '{'h1F1AD, 'h1F1E5}, '{'h1F203, 'h1F20F},
    '{'h1F23C, 'h1F23F}, '{'h1F249, 'h1F24F}, '{'h1F252, 'h1F2FF}, '{'h1F7D5, 'h1F7FF},
    '{'h1F000, 'h1F003}, '{'h1F005, 'h1F02F}, '{'h1F322, 'h1F323}, '{'h1F394, 'h1F395},
    '{'h1F398, 'h1F398}, '{'h1F39C, 'h1F39D}, '{'h1F3F1, 'h1F3F2}, '{'h1F3F6, 'h1F3F6},
    '{'h1F4FE, 'h1F4FE}, '{'h1F53E, 'h1F548}, '{'h1F54F, 'h1F54F}, '{'h1F568, 'h1F56E},
    '{'h1F571, 'h1F572}, '{'h1F57B, 'h1F586}, '{'h1F588, 'h1F589}, '{'h1F58E, 'h1F58F},
    '{'h1F591, 'h1F594}, '{'h1F597, 'h1F5A3}, '{'h1F5A6, 'h1F5A7}, '{'h1F5A9, 'h1F5B0},
    '{'h1F5B3, 'h1F5BB}, '{'h1F5BD, 'h1F5C1}, '{'h1F5C5, 'h1F5D0}, '{'h1F5D4, 'h1F5DB},
    '{'h1F5DF, 'h1F5E0}, '{'h1F5E2, 'h1F5E2}, '{'h1F5E4, 'h1F5E7}, '{'h1F5E9, 'h1F5EE},
    '{'h1F5F0, 'h1F5F2}, '{'h1F5F4, 'h1F5F9}, '{'h02605, 'h02605}, '{'h02607, 'h0260D},
    '{'h0260F, 'h02610}, '{'h02612, 'h02612}, '{'h02616, 'h02617}, '{'h02619, 'h0261C},
    '{'h0261E, 'h0261F}, '{'h02621, 'h02621}, '{'h02624, 'h02625}, '{'h02627, 'h02629},
    '{'h0262B, 'h0262D}, '{'h02630, 'h02637}, '{'h0263B, 'h02647}, '{'h02654, 'h0265F},
    '{'h02661, 'h02662}, '{'h02664, 'h02664}, '{'h02667, 'h02667}, '{'h02669, 'h0267A},
    '{'h0267C, 'h0267E}, '{'h02680, 'h02691}, '{'h02695, 'h02695}, '{'h02698, 'h02698},
    '{'h0269A, 'h0269A}, '{'h0269D, 'h0269F}, '{'h026A2, 'h026A9}, '{'h026AC, 'h026AF},
    '{'h026B2, 'h026BC}, '{'h026BF, 'h026C3}, '{'h026C6, 'h026C7}, '{'h026C9, 'h026CD},
    '{'h026D0, 'h026D0}, '{'h026D2, 'h026D2}, '{'h026D5, 'h026E8}, '{'h026EB, 'h026EF},
    '{'h026F6, 'h026F6}, '{'h026FB, 'h026FC}, '{'h026FE, 'h026FF}, '{'h02388, 'h02388},
    '{'h1FA00, 'h1FFFD}, '{'h1F0A0, 'h1F0FF}, '{'h1F80C, 'h1F80F}, '{'h1F848, 'h1F84F},
    '{'h1F85A, 'h1F85F}, '{'h1F888, 'h1F88F}, '{'h1F8AE, 'h1F90F}, '{'h1F91F, 'h1F91F},
    '{'h1F928, 'h1F92F}, '{'h1F931, 'h1F932}, '{'h1F93F, 'h1F93F}, '{'h1F94C, 'h1F94F},
    '{'h1F95F, 'h1F97F}, '{'h1F992, 'h1F9BF}, '{'h1F9C1, 'h1F9FF}, '{'h1F6C6, 'h1F6CA},
    '{'h1F6E6, 'h1F6E8}, '{'h1F6EA, 'h1F6EA}, '{'h1F6F1, 'h1F6F2}, '{'h1F6D3, 'h1F6DF},
    '{'h1F6ED, 'h1F6EF}, '{'h1F6F7, 'h1F6FF}
  };

  typedef struct packed {
    logic [CP_W-1:0] echo_point;
    logic            break_before;
    logic            text_end;
  } mark_t;

  class boundary_scoreboard;
    mark_t            expected_marks[$];
    int               errors;
    bit               have_prev;
    logic [CLS_W-1:0] prev_cls;
    bit               base_run;
    bit               pict_run;
    bit               zwj_pict;
    bit               ri_odd;

    function new();
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      have_prev = 1'b0;
      prev_cls  = CLS_OTHER;
      base_run  = 1'b0;
      pict_run  = 1'b0;
      zwj_pict  = 1'b0;
      ri_odd    = 1'b0;
    endfunction

    function int pending();
      return expected_marks.size();
    endfunction

    function void note_item(logic [CP_W-1:0] cp, logic [CLS_W-1:0] cls_in, logic emo,
                            logic last);
      logic [CLS_W-1:0] c;
      bit               pict;
      bit               brk;
      bit               cur_ctl;
      bit               prev_ctl;
      bit               keycap_like;
      mark_t            m;
      c = (cls_in > CLS_EBG) ? CLS_OTHER : cls_in;
      pict = 1'b0;
      for (int i = 0; i < SPAN_COUNT; i++) begin
        if (cp >= PICT_SPAN[i][0] && cp <= PICT_SPAN[i][1]) pict = 1'b1;
      end
      keycap_like = cp == CP_ASTERISK || cp == CP_HASH ||
                    (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_9) ||
                    cp == CP_COPYRIGHT || cp == CP_REGISTERED || cp == CP_TRADEMARK ||
                    cp == CP_WAVY_DASH || cp == CP_PART_ALT;
      if (emo && c != CLS_RI && !keycap_like) pict = 1'b1;
      cur_ctl  = c == CLS_CR || c == CLS_LF || c == CLS_CTL;
      prev_ctl = prev_cls == CLS_CR || prev_cls == CLS_LF || prev_cls == CLS_CTL;

      if (!have_prev) brk = 1'b1;
      else if (prev_cls == CLS_CR && c == CLS_LF) brk = 1'b0;
      else if (prev_ctl || cur_ctl) brk = 1'b1;
      else if (prev_cls == CLS_L &&
               (c == CLS_L || c == CLS_V || c == CLS_LV || c == CLS_LVT)) brk = 1'b0;
      else if ((prev_cls == CLS_LV || prev_cls == CLS_V) && (c == CLS_V || c == CLS_T))
        brk = 1'b0;
      else if ((prev_cls == CLS_LVT || prev_cls == CLS_T) && c == CLS_T) brk = 1'b0;
      else if (c == CLS_EXT || c == CLS_ZWJ || c == CLS_SM) brk = 1'b0;
      else if (prev_cls == CLS_PP) brk = 1'b0;
      else if (c == CLS_EM && base_run) brk = 1'b0;
      else if (zwj_pict && pict) brk = 1'b0;
      else if (prev_cls == CLS_RI && c == CLS_RI && ri_odd) brk = 1'b0;
      else brk = 1'b1;

      m.echo_point   = cp;
      m.break_before = brk;
      m.text_end     = last;
      expected_marks.push_back(m);

      if (last) begin
        clear_text();
      end else begin
        zwj_pict = c == CLS_ZWJ && pict_run;
        if (c != CLS_EXT) begin
          base_run = c == CLS_EB || c == CLS_EBG;
          pict_run = pict;
        end
        if (c == CLS_RI) ri_odd = (have_prev && prev_cls == CLS_RI) ? !ri_odd : 1'b1;
        else ri_odd = 1'b0;
        prev_cls  = c;
        have_prev = 1'b1;
      end
    endfunction

    function void check_mark(logic [CP_W-1:0] echo, logic brk, logic tend);
      mark_t m;
      if (expected_marks.size() == 0) begin
        $error("unexpected item: echo_point %h", echo);
        errors++;
        return;
      end
      m = expected_marks.pop_front();
      if (echo !== m.echo_point) begin
        $error("echo_point: expected %h, actual %h", m.echo_point, echo);
        errors++;
      end
      if (brk !== m.break_before) begin
        $error("break_before: expected %b, actual %b", m.break_before, brk);
        errors++;
      end
      if (tend !== m.text_end) begin
        $error("text_end: expected %b, actual %b", m.text_end, tend);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [CP_W-1:0]   in_code_point   = '0;
  logic [CLS_W-1:0]  in_break_class  = CLS_OTHER;
  logic              in_is_emoji     = 1'b0;
  logic              in_last_in_text = 1'b0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  logic [CP_W-1:0]   out_echo_point;
  logic              out_break_before;
  logic              out_text_end;

  boundary_scoreboard board = new();
  item_t              code_stream[$];
  int                 send_idle_pct = 0;
  int                 stall_pct     = 0;
  int                 quiet_cycles  = 0;

  grapheme_cluster_break_detector uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_code_point    (in_code_point),
    .in_break_class   (in_break_class),
    .in_is_emoji      (in_is_emoji),
    .in_last_in_text  (in_last_in_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_echo_point   (out_echo_point),
    .out_break_before (out_break_before),
    .out_text_end     (out_text_end)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        board.note_item(in_code_point, in_break_class, in_is_emoji, in_last_in_text);
      if (out_valid && out_ready)
        board.check_mark(out_echo_point, out_break_before, out_text_end);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("grapheme_cluster_break_detector verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic void add_item(logic [CP_W-1:0] cp, logic [CLS_W-1:0] cls, logic emo,
                                   logic last);
    item_t it;
    it.code_point   = cp;
    it.break_class  = cls;
    it.is_emoji     = emo;
    it.last_in_text = last;
    code_stream.push_back(it);
  endfunction

  function automatic logic [CP_W-1:0] pick_pictograph();
    int i;
    i = $urandom_range(SPAN_COUNT - 1);
    return PICT_SPAN[i][0] + $urandom_range(PICT_SPAN[i][1] - PICT_SPAN[i][0]);
  endfunction

  function automatic logic [CP_W-1:0] rand_point();
    int i;
    case ($urandom_range(7))
      0, 1: return $urandom_range(21'h1FFFFF);
      2: return pick_pictograph();
      3: begin
        case ($urandom_range(2))
          0: return CP_ASTERISK;
          1: return CP_HASH;
          default: return CP_DIGIT_0 + $urandom_range(9);
        endcase
      end
      4: begin
        case ($urandom_range(4))
          0: return CP_COPYRIGHT;
          1: return CP_REGISTERED;
          2: return CP_TRADEMARK;
          3: return CP_WAVY_DASH;
          default: return CP_PART_ALT;
        endcase
      end
      5: begin
        i = $urandom_range(SPAN_COUNT - 1);
        case ($urandom_range(5))
          0: return 21'h000000;
          1: return 21'h10FFFF;
          2: return 21'h110000;
          3: return 21'h1FFFFF;
          4: return PICT_SPAN[i][0] - 1;
          default: return PICT_SPAN[i][1] + 1;
        endcase
      end
      default: return $urandom_range(21'h10FFFF);
    endcase
  endfunction

  function automatic void add_extends(int most);
    repeat ($urandom_range(most))
      add_item(21'h0300 + $urandom_range(111), CLS_EXT, $urandom_range(7) == 0, 1'b0);
  endfunction

  function automatic void add_pictograph();
    logic [CLS_W-1:0] cls;
    case ($urandom_range(3))
      0: cls = CLS_GAZ;
      1: cls = CLS_EBG;
      2: cls = CLS_EB;
      default: cls = CLS_OTHER;
    endcase
    if ($urandom_range(1)) add_item(pick_pictograph(), cls, $urandom_range(1), 1'b0);
    else add_item(rand_point(), cls, 1'b1, 1'b0);
  endfunction

  function automatic void add_cluster();
    case ($urandom_range(9))
      0: begin
        add_item($urandom_range(1) ? 21'h41 + $urandom_range(57) : rand_point(),
                 CLS_OTHER, $urandom_range(3) == 0, 1'b0);
        add_extends(2);
      end
      1: begin
        case ($urandom_range(3))
          0: begin
            add_item(21'h0D, CLS_CR, 1'b0, 1'b0);
            add_item(21'h0A, CLS_LF, 1'b0, 1'b0);
          end
          1: add_item(21'h0D, CLS_CR, 1'b0, 1'b0);
          2: add_item(21'h0A, CLS_LF, 1'b0, 1'b0);
          default: add_item($urandom_range(31), CLS_CTL, 1'b0, 1'b0);
        endcase
      end
      2: begin
        repeat ($urandom_range(2)) add_item(21'h1100 + $urandom_range(18), CLS_L, 1'b0, 1'b0);
        if ($urandom_range(1))
          add_item(21'hAC00 + $urandom_range(11171), $urandom_range(1) ? CLS_LV : CLS_LVT,
                   1'b0, 1'b0);
        else
          repeat ($urandom_range(1, 2))
            add_item(21'h1161 + $urandom_range(20), CLS_V, 1'b0, 1'b0);
        repeat ($urandom_range(2)) add_item(21'h11A8 + $urandom_range(26), CLS_T, 1'b0, 1'b0);
      end
      3: begin
        add_item(21'h1F466 + $urandom_range(3), $urandom_range(1) ? CLS_EB : CLS_EBG,
                 1'b1, 1'b0);
        add_extends(1);
        add_item(21'h1F3FB + $urandom_range(4), CLS_EM, 1'b1, 1'b0);
        add_extends(1);
      end
      4: begin
        add_pictograph();
        repeat ($urandom_range(1, 3)) begin
          add_extends(1);
          add_item(21'h200D, CLS_ZWJ, 1'b0, 1'b0);
          add_pictograph();
        end
      end
      5: begin
        repeat ($urandom_range(1, 5))
          add_item(21'h1F1E6 + $urandom_range(25), CLS_RI, $urandom_range(3) != 0, 1'b0);
      end
      6: begin
        add_item(21'h0600 + $urandom_range(5), CLS_PP, 1'b0, 1'b0);
        add_item(rand_point(), CLS_OTHER, 1'b0, 1'b0);
        add_item(21'h0903 + $urandom_range(8), CLS_SM, 1'b0, 1'b0);
        add_extends(1);
      end
      7: begin
        case ($urandom_range(3))
          0: begin
            add_item(21'h61, CLS_OTHER, 1'b0, 1'b0);
            add_extends(1);
            add_item(21'h1F3FB + $urandom_range(4), CLS_EM, 1'b1, 1'b0);
          end
          1: begin
            add_item(rand_point(), CLS_OTHER, 1'b0, 1'b0);
            add_item(21'h200D, CLS_ZWJ, 1'b0, 1'b0);
            add_pictograph();
          end
          2: begin
            add_item(21'h200D, CLS_ZWJ, 1'b0, 1'b0);
            add_extends(2);
          end
          default: begin
            add_item(CP_DIGIT_0 + $urandom_range(9), CLS_OTHER, 1'b1, 1'b0);
            add_item(21'h20E3, CLS_EXT, 1'b0, 1'b0);
            add_item(21'h200D, CLS_ZWJ, 1'b0, 1'b0);
            add_pictograph();
          end
        endcase
      end
      default: begin
        repeat ($urandom_range(1, 3))
          add_item($urandom_range(21'h1FFFFF), $urandom_range(31), $urandom_range(1),
                   $urandom_range(7) == 0);
      end
    endcase
  endfunction

  function automatic void add_text();
    item_t tail;
    repeat ($urandom_range(1, 5)) add_cluster();
    if ($urandom_range(3) != 0) begin
      tail = code_stream.pop_back();
      tail.last_in_text = 1'b1;
      code_stream.push_back(tail);
    end
  endfunction

  task automatic send_stream();
    item_t it;
    while (code_stream.size() != 0) begin
      it = code_stream.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid        <= 1'b1;
      in_code_point   <= it.code_point;
      in_break_class  <= it.break_class;
      in_is_emoji     <= it.is_emoji;
      in_last_in_text <= it.last_in_text;
      do @(posedge clk); while (!in_ready);
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    int idle_plan [4];
    int stall_plan [4];
    idle_plan  = '{0, 51, 0, 36};
    stall_plan = '{0, 0, 51, 36};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_item(21'h000000, CLS_CR, 1'b0, 1'b0);
    add_item(21'h00000A, CLS_LF, 1'b0, 1'b0);
    add_item(21'h000007, CLS_CTL, 1'b0, 1'b0);
    add_item(21'h000061, CLS_OTHER, 1'b0, 1'b0);
    add_item(21'h000301, CLS_EXT, 1'b0, 1'b0);
    add_item(21'h00200D, CLS_ZWJ, 1'b0, 1'b0);
    add_item(21'h000903, CLS_SM, 1'b0, 1'b0);
    add_item(21'h000600, CLS_PP, 1'b0, 1'b0);
    add_item(21'h001100, CLS_L, 1'b0, 1'b0);
    add_item(21'h001161, CLS_V, 1'b0, 1'b0);
    add_item(21'h0011A8, CLS_T, 1'b0, 1'b0);
    add_item(21'h00AC00, CLS_LV, 1'b0, 1'b0);
    add_item(21'h00AC01, CLS_LVT, 1'b0, 1'b0);
    add_item(21'h01F466, CLS_EB, 1'b1, 1'b0);
    add_item(21'h01F3FB, CLS_EM, 1'b1, 1'b0);
    add_item(21'h01F468, CLS_EBG, 1'b1, 1'b0);
    add_item(21'h00200D, CLS_ZWJ, 1'b0, 1'b0);
    add_item(21'h01F469, CLS_GAZ, 1'b1, 1'b0);
    add_item(21'h01F1FA, CLS_RI, 1'b1, 1'b0);
    add_item(21'h01F1F8, CLS_RI, 1'b1, 1'b0);
    add_item(21'h01F1E6, CLS_RI, 1'b1, 1'b0);
    add_item(21'h01F3FB, CLS_EM, 1'b1, 1'b0);
    add_item(21'h1FFFFF, 5'd31, 1'b0, 1'b0);
    add_item(21'h00200D, CLS_ZWJ, 1'b0, 1'b0);
    add_item(21'h002700, CLS_OTHER, 1'b0, 1'b0);
    add_item(21'h10FFFF, CLS_OTHER, 1'b0, 1'b1);
    send_stream();
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      while (code_stream.size() < 100) add_text();
      send_stream();
      // hold the sender until the block has emptied
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("grapheme_cluster_break_detector verification clean");
    else
      $display("grapheme_cluster_break_detector verification failed");
    $finish;
  end

endmodule
